// ===== hw/rtl/mpct_pkg.sv =====
// shared types and constants for the mouse packet cursor tracker
`default_nettype none

package mpct_pkg;

  // default cursor coordinate width
  localparam int COORD_BITS_DEF = 12;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MODE    = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 13'd768;

  // bit positions inside the first packet byte
  localparam int SYNC_BIT   = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;

  // packets held between front and back
  localparam int QUEUE_DEPTH = 2;

  // one assembled packet
  typedef struct packed {
    logic [1:0] buttons;
    logic       x_neg;
    logic       y_neg;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wheel;
  } pkt_t;

  // front to queue
  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } push_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mpct_front.sv =====
// byte assembler: resynchronizes on the first byte and builds packets
`default_nettype none

module mpct_front
  import mpct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            in_ready,
  input  wire logic       wheel_mode,
  input  wire qstat_t     qstat,
  output push_t           push
);

  typedef enum logic [3:0] {
    PH_HEAD  = 4'b0001,
    PH_DX    = 4'b0010,
    PH_DY    = 4'b0100,
    PH_WHEEL = 4'b1000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] head_r, head_nxt;
  logic [7:0] dx_r, dx_nxt;
  logic [7:0] dy_r, dy_nxt;
  logic [7:0] last_wheel_r, last_wheel_nxt;
  logic       acc;
  logic       done;

  // a completing byte needs room in the queue, others are held back with it
  assign in_ready = !qstat.full;
  assign acc      = in_valid && in_ready;

  // phase sequencing and byte capture
  always_comb begin
    phase_nxt      = phase_r;
    head_nxt       = head_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    last_wheel_nxt = last_wheel_r;
    done           = 1'b0;
    if (acc) begin
      case (phase_r)
        PH_HEAD: begin
          if (in_byte[SYNC_BIT]) begin
            head_nxt  = in_byte;
            phase_nxt = PH_DX;
          end
        end
        PH_DX: begin
          dx_nxt    = in_byte;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          dy_nxt = in_byte;
          if (wheel_mode) begin
            phase_nxt = PH_WHEEL;
          end else begin
            phase_nxt = PH_HEAD;
            done      = 1'b1;
          end
        end
        PH_WHEEL: begin
          phase_nxt = PH_HEAD;
          done      = 1'b1;
          if (wheel_mode) last_wheel_nxt = in_byte;
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase
    end
  end

  // packet record for the back end
  always_comb begin
    push.valid       = done;
    push.pkt.buttons = head_r[1:0];
    push.pkt.x_neg   = head_r[X_SIGN_BIT];
    push.pkt.y_neg   = head_r[Y_SIGN_BIT];
    push.pkt.dx      = dx_r;
    push.pkt.dy      = dy_nxt;
    push.pkt.wheel   = last_wheel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEAD;
      last_wheel_r <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      last_wheel_r <= last_wheel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpct_queue.sv =====
// short packet queue between the front and the back end
`default_nettype none

module mpct_queue
  import mpct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output pkt_t       head,
  output qstat_t     qstat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  pkt_t          slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  assign qstat.full  = (cnt_r == FULL_CNT);
  assign qstat.empty = (cnt_r == '0);
  assign head        = slot_r[rd_ptr_r];

  assign do_wr = push.valid && !qstat.full;
  assign do_rd = pop && !qstat.empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // packet storage
  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= push.pkt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpct_back.sv =====
// cursor update, clamping and the registered result stage
`default_nettype none

module mpct_back
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pkt_t                  pkt,
  input  wire qstat_t                qstat,
  output logic                       pop,
  input  wire logic [CFG_W-1:0]      screen_width,
  input  wire logic [CFG_W-1:0]      screen_height,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_BITS-1:0]      cursor_x,
  output logic [COORD_BITS-1:0]      cursor_y,
  output logic [1:0]                 buttons,
  output logic [7:0]                 wheel_delta
);

  localparam int SUM_W = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;
  localparam logic [SUM_W-1:0] CMAX = SUM_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [COORD_BITS-1:0] RST_X = COORD_BITS'(RST_SCREEN_WIDTH >> 1);
  localparam logic [COORD_BITS-1:0] RST_Y = COORD_BITS'(RST_SCREEN_HEIGHT >> 1);

  logic [COORD_BITS-1:0]   pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0]   pos_y_r, pos_y_nxt;
  logic                    out_valid_r;
  logic [COORD_BITS-1:0]   cur_x_r, cur_y_r;
  logic [1:0]              buttons_r;
  logic [7:0]              wheel_r;
  logic [SUM_W-1:0]        lim_x, lim_y;
  logic signed [9:0]       dx2, dy2;
  logic signed [SUM_W-1:0] vx, vy;

  // clamp limits: size minus one, zero size holds at 0, capped at coordinate range
  function automatic logic [SUM_W-1:0] limit_of(input logic [CFG_W-1:0] size);
    logic [SUM_W-1:0] lim;
    lim = (size == '0) ? '0 : ({{(SUM_W-CFG_W){1'b0}}, size} - 1'b1);
    return (lim > CMAX) ? CMAX : lim;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_to(input logic signed [SUM_W-1:0] v,
                                                     input logic [SUM_W-1:0] hi);
    logic [SUM_W-1:0] r;
    if (v[SUM_W-1]) r = '0;
    else if (SUM_W'(v) > hi) r = hi;
    else r = SUM_W'(v);
    return r[COORD_BITS-1:0];
  endfunction

  assign lim_x = limit_of(screen_width);
  assign lim_y = limit_of(screen_height);

  // twice the nine-bit moves
  assign dx2 = {pkt.x_neg, pkt.dx, 1'b0};
  assign dy2 = {pkt.y_neg, pkt.dy, 1'b0};

  // move the cursor, y grows downward
  assign vx = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_x_r})
            + {{(SUM_W-10){dx2[9]}}, dx2};
  assign vy = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_y_r})
            - {{(SUM_W-10){dy2[9]}}, dy2};

  assign pos_x_nxt = clamp_to(vx, lim_x);
  assign pos_y_nxt = clamp_to(vy, lim_y);

  // take a packet when the result stage is free or being drained
  assign pop = !qstat.empty && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= RST_X;
      pos_y_r     <= RST_Y;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_x_r   <= pos_x_nxt;
      cur_y_r   <= pos_y_nxt;
      buttons_r <= pkt.buttons;
      wheel_r   <= pkt.wheel;
    end
  end

  assign out_valid   = out_valid_r;
  assign cursor_x    = cur_x_r;
  assign cursor_y    = cur_y_r;
  assign buttons     = buttons_r;
  assign wheel_delta = wheel_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mouse_packet_cursor_tracker.sv =====
// top level of the mouse packet cursor tracker
`default_nettype none

// Takes one mouse byte per transfer and can accept a byte every cycle while
// the queue has room. Bytes are gathered into three-byte packets, or
// four-byte packets with wheel_mode set; a first byte without bit 3 is
// dropped to regain sync. A completed packet moves the cursor by twice the X
// move and minus twice the Y move, clamps it to the screen, and raises
// out_tvalid once the packet has passed through the queue slot and the
// result register. A two-packet queue sits between the byte assembler and
// the cursor stage, so bytes keep flowing while a result waits; in_tready
// drops only when that queue is full. There is no clearing pass after
// reset. Registers: 0 screen width, 1 screen height, 2 wheel mode;
// write them only while no result is outstanding.

module mouse_packet_cursor_tracker
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  // byte input
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,  // [7:0] rx_byte
  // result output
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cursor_x, cursor_y, buttons[1:0], wheel_delta[7:0], zero padding
  output logic [((2*COORD_BITS+10+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_W = ((2*COORD_BITS+10+7)/8)*8;
  localparam int PAD_W = OUT_W - (2*COORD_BITS+10);

  logic [CFG_W-1:0]      screen_width_r;
  logic [CFG_W-1:0]      screen_height_r;
  logic                  wheel_mode_r;
  push_t                 push;
  pkt_t                  q_head;
  qstat_t                qstat;
  logic                  pop;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [1:0]            buttons;
  logic [7:0]            wheel_delta;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      wheel_mode_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        REG_WHEEL_MODE:    wheel_mode_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // byte assembler
  mpct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_ready   (in_tready),
    .wheel_mode (wheel_mode_r),
    .qstat      (qstat),
    .push       (push)
  );

  // packet queue
  mpct_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (q_head),
    .qstat (qstat)
  );

  // cursor stage
  mpct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pkt           (q_head),
    .qstat         (qstat),
    .pop           (pop),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .buttons       (buttons),
    .wheel_delta   (wheel_delta)
  );

  assign out_tdata = {{PAD_W{1'b0}}, wheel_delta, buttons, cursor_y, cursor_x};

  // a completed packet never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !qstat.full)
    else $error("packet pushed into a full queue");

  // the front stalls only on a full queue
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> qstat.full)
    else $error("input stalled with room in the queue");

  // a shown cursor column lies within a nonzero screen width
  a_x_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && screen_width_r != '0 && COORD_BITS >= CFG_W) |->
      ({{(CFG_W+1){1'b0}}, cursor_x} <
       {{(COORD_BITS+1){1'b0}}, screen_width_r}))
    else $error("cursor column outside the screen");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    ($past(!rst_n) && rst_n) |-> !out_tvalid)
    else $error("result offered right after reset");

endmodule

`default_nettype wire
